FILE: rtl/core/bpme_pkg.sv
`default_nettype none
package bpme_pkg;

  localparam int TEXT_AW  = 16;
  localparam int LINK_W   = 17;
  localparam int ID_W     = 10;
  localparam int CNT_W    = 16;
  localparam int KEY_W    = 20;
  localparam int PAIR_AW  = 13;
  localparam int MAX_MERGES = 512;

  localparam logic [LINK_W-1:0] NO_LINK     = 17'h1FFFF;
  localparam logic [ID_W-1:0]   FIRST_ID    = 10'd256;
  localparam logic [ID_W:0]     ID_LIMIT    = 11'd1024;
  localparam logic [PAIR_AW-1:0] HASH_MULT  = 13'h19B1;
  localparam logic [PAIR_AW-1:0] PAIR_LAST  = 13'h1FFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_MERGED    = 3'd1,
    ST_NO_PAIR   = 3'd2,
    ST_ID_LIMIT  = 3'd3,
    ST_TEXT_FULL = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DONE,
    S_A_WR, S_A_LNK, S_A_DAT, S_A_FIN,
    S_SCAN, S_SCAN_END, S_DECIDE,
    S_W_TEST, S_W_L, S_W_RRD, S_W_R,
    S_M_PRD, S_M_PDAT, S_M_QRD, S_M_QDAT, S_M_AB, S_M_WR, S_M_LNK, S_M_BP, S_M_BQ,
    S_P_HASH, S_P_RD, S_P_CHK,
    S_F_START, S_F_RD, S_F_DAT, S_F_CMP, S_F_END
  } state_t;

  // one pair table entry
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } pair_ent_t;

  // per-field write enables of the text store
  typedef struct packed {
    logic tok;
    logic prev;
    logic next;
  } text_we_t;

  // multiplicative hash, only the low slot bits of the product matter
  function automatic logic [PAIR_AW-1:0] pair_hash(input logic [KEY_W-1:0] key);
    logic [2*PAIR_AW-1:0] prod;
    prod = key[PAIR_AW-1:0] * HASH_MULT;
    return prod[PAIR_AW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bpme_text_mem.sv
`default_nettype none
module bpme_text_mem
  import bpme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [TEXT_AW-1:0] addr,
  input  wire text_we_t          we,
  input  wire logic [ID_W-1:0]   wr_tok,
  input  wire logic [LINK_W-1:0] wr_prev,
  input  wire logic [LINK_W-1:0] wr_next,
  output logic [ID_W-1:0]        rd_tok,
  output logic [LINK_W-1:0]      rd_prev,
  output logic [LINK_W-1:0]      rd_next
);

  logic [ID_W-1:0]   tok_mem  [2**TEXT_AW];
  logic [LINK_W-1:0] prev_mem [2**TEXT_AW];
  logic [LINK_W-1:0] next_mem [2**TEXT_AW];

  // token ids
  always_ff @(posedge clk) begin
    if (we.tok) tok_mem[addr] <= wr_tok;
    rd_tok <= tok_mem[addr];
  end

  // backward links
  always_ff @(posedge clk) begin
    if (we.prev) prev_mem[addr] <= wr_prev;
    rd_prev <= prev_mem[addr];
  end

  // forward links
  always_ff @(posedge clk) begin
    if (we.next) next_mem[addr] <= wr_next;
    rd_next <= next_mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/bpme_pair_mem.sv
`default_nettype none
module bpme_pair_mem
  import bpme_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [PAIR_AW-1:0] addr,
  input  wire logic               we,
  input  wire pair_ent_t          wdata,
  output pair_ent_t               rdata
);

  pair_ent_t mem [2**PAIR_AW];

  // single port, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/byte_pair_merge_engine_top.sv
`default_nettype none
// Byte-pair-encoding trainer. Append words (cmd 0) store a byte at the end of a linked token
// chain and count the new adjacent pair in a hashed 8192-entry pair table. Merge words (cmd 1)
// first sweep the whole pair table for the highest count, one entry per cycle through the
// single table port, then walk the chain one token at a time; each match updates the pair
// table through the probe and back-shift loops of the shared table port. Clear words (cmd 2
// or 3) sweep the pair table; the same sweep runs after reset, and no word is taken until it
// ends. The input is stalled while a word is in work; a finished result waits in the output
// register.
module byte_pair_merge_engine_top
  import bpme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [9:0]       out_left_id,
  output logic [9:0]       out_right_id,
  output logic [9:0]       out_new_id,
  output logic [15:0]      out_pair_count,
  output logic [16:0]      out_live_tokens,
  output logic             out_table_overflow
);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  status_t status_r, status_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [LINK_W-1:0] len_r, len_nxt, live_r, live_nxt;
  logic [TEXT_AW-1:0] head_r, head_nxt;
  logic [ID_W-1:0]   nsym_r, nsym_nxt, a_r, a_nxt, b_r, b_nxt, nid_r, nid_nxt;
  logic [ID_W-1:0]   tokp_r, tokp_nxt, tokq_r, tokq_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt, p_r, p_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              drop_r, drop_nxt;
  logic [PAIR_AW-1:0] slot_r, slot_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  pair_ent_t         ent_r, ent_nxt;
  logic [CNT_W+KEY_W-1:0] best_r, best_nxt;
  logic              found_r, found_nxt, sv_r, sv_nxt;
  logic              load_out;
  logic              move;
  logic [CNT_W+KEY_W-1:0] cand;
  logic [ID_W:0]     merges_done;

  logic [TEXT_AW-1:0] t_addr;
  text_we_t           t_we;
  logic [ID_W-1:0]    t_wtok, t_rtok;
  logic [LINK_W-1:0]  t_wprev, t_wnext, t_rprev, t_rnext;
  logic [PAIR_AW-1:0] p_addr;
  logic               p_we;
  pair_ent_t          p_wdata, p_rdata;

  bpme_text_mem u_text (
    .clk(clk), .addr(t_addr), .we(t_we), .wr_tok(t_wtok), .wr_prev(t_wprev),
    .wr_next(t_wnext), .rd_tok(t_rtok), .rd_prev(t_rprev), .rd_next(t_rnext)
  );

  bpme_pair_mem u_pair (
    .clk(clk), .addr(p_addr), .we(p_we), .wdata(p_wdata), .rdata(p_rdata)
  );

  assign in_stall    = (state_r != S_IDLE);
  assign cand        = {p_rdata.count, p_rdata.key};
  assign merges_done = {1'b0, nsym_r} - {1'b0, FIRST_ID};

  // back-shift test for the slot being freed
  always_comb begin
    if (j_r > i_r) move = (k_r <= i_r) || (k_r > j_r);
    else           move = (k_r <= i_r) && (k_r > j_r);
  end

  // sequencer: next state, memory ports and datapath updates
  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  status_nxt = status_r;
    byte_nxt = byte_r;  len_nxt = len_r;  live_nxt = live_r;  head_nxt = head_r;
    nsym_nxt = nsym_r;  a_nxt = a_r;  b_nxt = b_r;  nid_nxt = nid_r;  cnt_nxt = cnt_r;
    tokp_nxt = tokp_r;  tokq_nxt = tokq_r;  ovf_nxt = ovf_r;
    cur_nxt = cur_r;  p_nxt = p_r;  q_nxt = q_r;  r_nxt = r_r;
    key_nxt = key_r;  drop_nxt = drop_r;  slot_nxt = slot_r;  n_nxt = n_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;  ent_nxt = ent_r;
    best_nxt = best_r;  found_nxt = found_r;  sv_nxt = sv_r;
    load_out = 1'b0;
    t_addr = cur_r[TEXT_AW-1:0];  t_we = '0;
    t_wtok = '0;  t_wprev = NO_LINK;  t_wnext = NO_LINK;
    p_addr = slot_r;  p_we = 1'b0;  p_wdata = '0;

    unique case (state_r)
      S_CLR: begin
        p_addr = j_r;
        p_we   = 1'b1;
        j_nxt  = j_r + 1'b1;
        if (j_r == PAIR_LAST) state_nxt = ret_r;
      end
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_text_byte;
          if (in_cmd[1]) begin
            len_nxt = '0;  head_nxt = '0;  live_nxt = '0;
            status_nxt = ST_CLEARED;
            j_nxt = '0;  ret_nxt = S_DONE;  state_nxt = S_CLR;
          end else if (in_cmd[0]) begin
            j_nxt = '0;  sv_nxt = 1'b0;  found_nxt = 1'b0;  state_nxt = S_SCAN;
          end else if (len_r[LINK_W-1]) begin
            status_nxt = ST_TEXT_FULL;  state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_WR;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // append a byte
      S_A_WR: begin
        t_addr = len_r[TEXT_AW-1:0];
        t_we   = '{tok: 1'b1, prev: 1'b1, next: 1'b1};
        t_wtok = {2'b00, byte_r};
        t_wnext = NO_LINK;
        if (len_r == '0) begin
          t_wprev = NO_LINK;  head_nxt = '0;  state_nxt = S_A_FIN;
        end else begin
          t_wprev = len_r - 1'b1;  state_nxt = S_A_LNK;
        end
      end
      S_A_LNK: begin
        t_addr  = len_r[TEXT_AW-1:0] - 1'b1;
        t_we    = '{tok: 1'b0, prev: 1'b0, next: 1'b1};
        t_wnext = len_r;
        state_nxt = S_A_DAT;
      end
      S_A_DAT: begin
        key_nxt = {t_rtok, 2'b00, byte_r};  drop_nxt = 1'b0;
        ret_nxt = S_A_FIN;  state_nxt = S_P_HASH;
      end
      S_A_FIN: begin
        len_nxt = len_r + 1'b1;  live_nxt = live_r + 1'b1;
        status_nxt = ST_STORED;  state_nxt = S_DONE;
      end

      // argmax sweep over the pair table
      S_SCAN: begin
        p_addr = j_r;
        sv_nxt = 1'b1;
        j_nxt  = j_r + 1'b1;
        if (sv_r && p_rdata.valid && (!found_r || cand > best_r)) begin
          best_nxt = cand;  found_nxt = 1'b1;
        end
        if (j_r == PAIR_LAST) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        if (p_rdata.valid && (!found_r || cand > best_r)) begin
          best_nxt = cand;  found_nxt = 1'b1;
        end
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!found_r) begin
          status_nxt = ST_NO_PAIR;  state_nxt = S_DONE;
        end else if (merges_done >= (ID_W+1)'(MAX_MERGES) || {1'b0, nsym_r} >= ID_LIMIT) begin
          status_nxt = ST_ID_LIMIT;  state_nxt = S_DONE;
        end else begin
          a_nxt   = best_r[KEY_W-1:ID_W];
          b_nxt   = best_r[ID_W-1:0];
          cnt_nxt = best_r[CNT_W+KEY_W-1:KEY_W];
          nid_nxt = nsym_r;
          nsym_nxt = nsym_r + 1'b1;
          status_nxt = ST_MERGED;
          cur_nxt = (live_r != '0) ? {1'b0, head_r} : NO_LINK;
          state_nxt = S_W_TEST;
        end
      end

      // chain walk
      S_W_TEST: begin
        t_addr = cur_r[TEXT_AW-1:0];
        if (cur_r[LINK_W-1]) state_nxt = S_DONE;
        else                 state_nxt = S_W_L;
      end
      S_W_L: begin
        p_nxt = t_rprev;
        r_nxt = t_rnext;
        if (t_rnext[LINK_W-1] || t_rtok != a_r) begin
          cur_nxt = t_rnext;  state_nxt = S_W_TEST;
        end else begin
          state_nxt = S_W_RRD;
        end
      end
      S_W_RRD: begin
        t_addr = r_r[TEXT_AW-1:0];
        state_nxt = S_W_R;
      end
      S_W_R: begin
        q_nxt = t_rnext;
        if (t_rtok != b_r) begin
          cur_nxt = r_r;  state_nxt = S_W_TEST;
        end else begin
          state_nxt = S_M_PRD;
        end
      end

      // merge one occurrence
      S_M_PRD: begin
        t_addr = p_r[TEXT_AW-1:0];
        state_nxt = p_r[LINK_W-1] ? S_M_QRD : S_M_PDAT;
      end
      S_M_PDAT: begin
        tokp_nxt = t_rtok;
        key_nxt = {t_rtok, a_r};  drop_nxt = 1'b1;
        ret_nxt = S_M_QRD;  state_nxt = S_P_HASH;
      end
      S_M_QRD: begin
        t_addr = q_r[TEXT_AW-1:0];
        state_nxt = q_r[LINK_W-1] ? S_M_AB : S_M_QDAT;
      end
      S_M_QDAT: begin
        tokq_nxt = t_rtok;
        key_nxt = {b_r, t_rtok};  drop_nxt = 1'b1;
        ret_nxt = S_M_AB;  state_nxt = S_P_HASH;
      end
      S_M_AB: begin
        key_nxt = {a_r, b_r};  drop_nxt = 1'b1;
        ret_nxt = S_M_WR;  state_nxt = S_P_HASH;
      end
      S_M_WR: begin
        t_addr  = r_r[TEXT_AW-1:0];
        t_we    = '{tok: 1'b1, prev: 1'b1, next: 1'b0};
        t_wtok  = nid_r;
        t_wprev = p_r;
        state_nxt = S_M_LNK;
      end
      S_M_LNK: begin
        t_addr  = p_r[TEXT_AW-1:0];
        t_wnext = r_r;
        if (p_r[LINK_W-1]) head_nxt = r_r[TEXT_AW-1:0];
        else               t_we = '{tok: 1'b0, prev: 1'b0, next: 1'b1};
        live_nxt = live_r - 1'b1;
        state_nxt = S_M_BP;
      end
      S_M_BP: begin
        if (p_r[LINK_W-1]) begin
          state_nxt = S_M_BQ;
        end else begin
          key_nxt = {tokp_r, nid_r};  drop_nxt = 1'b0;
          ret_nxt = S_M_BQ;  state_nxt = S_P_HASH;
        end
      end
      S_M_BQ: begin
        cur_nxt = r_r;
        if (q_r[LINK_W-1]) begin
          state_nxt = S_W_TEST;
        end else begin
          key_nxt = {nid_r, tokq_r};  drop_nxt = 1'b0;
          ret_nxt = S_W_TEST;  state_nxt = S_P_HASH;
        end
      end

      // pair count bump or drop: linear probe from the home slot
      S_P_HASH: begin
        slot_nxt = pair_hash(key_r);
        n_nxt = '0;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        if (p_rdata.valid && p_rdata.key == key_r) begin
          p_wdata = p_rdata;
          if (drop_r) begin
            if (p_rdata.count <= CNT_W'(1)) begin
              state_nxt = S_F_START;
            end else begin
              p_wdata.count = p_rdata.count - 1'b1;
              p_we = 1'b1;  state_nxt = ret_r;
            end
          end else begin
            if (p_rdata.count != COUNT_MAX) p_wdata.count = p_rdata.count + 1'b1;
            p_we = 1'b1;  state_nxt = ret_r;
          end
        end else if (!p_rdata.valid) begin
          if (!drop_r) begin
            p_wdata = '{valid: 1'b1, key: key_r, count: CNT_W'(1)};
            p_we = 1'b1;
          end
          state_nxt = ret_r;
        end else if (n_r == PAIR_LAST) begin
          if (!drop_r) ovf_nxt = 1'b1;
          state_nxt = ret_r;
        end else begin
          slot_nxt = slot_r + 1'b1;
          n_nxt = n_r + 1'b1;
          state_nxt = S_P_RD;
        end
      end

      // free a slot, shifting later run entries back
      S_F_START: begin
        i_nxt = slot_r;  j_nxt = slot_r + 1'b1;  n_nxt = '0;
        state_nxt = S_F_RD;
      end
      S_F_RD: begin
        p_addr = j_r;
        state_nxt = S_F_DAT;
      end
      S_F_DAT: begin
        if (!p_rdata.valid) begin
          state_nxt = S_F_END;
        end else begin
          ent_nxt = p_rdata;
          k_nxt = pair_hash(p_rdata.key);
          state_nxt = S_F_CMP;
        end
      end
      S_F_CMP: begin
        p_addr = i_r;
        if (move) begin
          p_wdata = '{valid: 1'b1, key: ent_r.key, count: ent_r.count};
          p_we = 1'b1;
          i_nxt = j_r;
        end
        if (n_r == PAIR_LAST) begin
          state_nxt = S_F_END;
        end else begin
          n_nxt = n_r + 1'b1;  j_nxt = j_r + 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_F_END: begin
        p_addr = i_r;
        p_we = 1'b1;
        p_wdata = '0;
        state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;  ret_r <= S_IDLE;  j_r <= '0;
      len_r <= '0;  live_r <= '0;  head_r <= '0;
      nsym_r <= FIRST_ID;  ovf_r <= 1'b0;  out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;  ret_r <= ret_nxt;  j_r <= j_nxt;
      len_r <= len_nxt;  live_r <= live_nxt;  head_r <= head_nxt;
      nsym_r <= nsym_nxt;  ovf_r <= ovf_nxt;
      if (load_out)                  out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;  byte_r <= byte_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  nid_r <= nid_nxt;  cnt_r <= cnt_nxt;
    tokp_r <= tokp_nxt;  tokq_r <= tokq_nxt;
    cur_r <= cur_nxt;  p_r <= p_nxt;  q_r <= q_nxt;  r_r <= r_nxt;
    key_r <= key_nxt;  drop_r <= drop_nxt;  slot_r <= slot_nxt;  n_r <= n_nxt;
    i_r <= i_nxt;  k_r <= k_nxt;  ent_r <= ent_nxt;
    best_r <= best_nxt;  found_r <= found_nxt;  sv_r <= sv_nxt;
  end

  // result word
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status         <= status_r;
      out_left_id        <= (status_r == ST_MERGED) ? a_r : '0;
      out_right_id       <= (status_r == ST_MERGED) ? b_r : '0;
      out_new_id         <= (status_r == ST_MERGED) ? nid_r : '0;
      out_pair_count     <= (status_r == ST_MERGED) ? cnt_r : '0;
      out_live_tokens    <= live_r;
      out_table_overflow <= ovf_r;
    end
  end

  a_live_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= len_r) else $error("live token count above text length");

  a_nsym_range: assert property (@(posedge clk) disable iff (!rst_n)
    nsym_r >= FIRST_ID) else $error("next symbol id below first merge id");

  a_head_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    live_r != '0 |-> {1'b0, head_r} < len_r) else $error("chain head outside stored text");

  a_merge_id: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && status_r == ST_MERGED |=> nsym_r == out_new_id + 1'b1)
    else $error("merged word id out of step with symbol counter");

endmodule
`default_nettype wire
